// File: sv/efrs_pkg.sv
// Package with the shared types and constants of the exact floating-point running sum.
package efrs_pkg;

  localparam int unsigned DefMaxTerms = 64;
  localparam logic [63:0] DefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QuietBit = 64'h0008_0000_0000_0000;
  localparam logic [10:0] ExpAllOnes = 11'h7FF;

  typedef enum logic [3:0] {
    S_IDLE, S_TERM_RD, S_TERM_WAIT, S_TS_GO, S_TS_BUSY, S_FIN,
    S_TOP_RD, S_TOP_WAIT, S_TOP_GO, S_TOP_BUSY,
    S_SUM_RD, S_SUM_WAIT, S_SUM_GO, S_SUM_BUSY, S_EMIT
  } seq_state_e;

  typedef enum logic [2:0] {
    A_IDLE, A_PREP, A_ALIGN, A_ADD, A_LZC, A_NORM, A_ROUND, A_DONE
  } add_state_e;

  typedef enum logic [2:0] {
    OP_X, OP_BV, OP_AV, OP_BR, OP_AR, OP_Y
  } ts_op_e;

  typedef struct packed {
    logic        start;
    logic        sub;
    logic [63:0] a;
    logic [63:0] b;
  } add_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } add_rsp_t;

endpackage

// File: sv/efrs_ram.sv
// Generic single-port-write, registered-read RAM.
module efrs_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/efrs_fpadd.sv
// Multi-cycle IEEE double adder and subtractor with round to nearest even.
module efrs_fpadd
  import efrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  add_req_t req_i,
  output add_rsp_t rsp_o
);

  add_state_e state_q, state_d;

  logic [63:0] opa_q, opb_q;
  logic        sub_q;
  logic [63:0] res_q;
  logic        sign_q, zsign_q, effsub_q;
  logic [11:0] e_q;
  logic [10:0] d_q;
  logic [55:0] bm_q, sm_q, nrm_q;
  logic [56:0] sum_q;
  logic [5:0]  sh_q;

  logic        sbn, nan_a, nan_b, inf_a, inf_b, b_big;
  logic [63:0] big, sml;
  logic [10:0] eb_raw, es_raw, eb_adj, es_adj;
  logic [55:0] sm_in, sm_shift, sm_mask;
  logic [5:0]  lz;
  logic [55:0] nrm_pre;
  logic [52:0] m53;
  logic [53:0] m54;
  logic [52:0] mfin;
  logic [11:0] efin;
  logic        rnd_up;

  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE:  if (req_i.start) state_d = A_PREP;
      A_PREP: begin
        if (nan_a || nan_b || inf_a || inf_b) state_d = A_DONE;
        else state_d = A_ALIGN;
      end
      A_ALIGN: state_d = A_ADD;
      A_ADD:   state_d = A_LZC;
      A_LZC:   state_d = (sum_q == '0) ? A_DONE : A_NORM;
      A_NORM:  state_d = A_ROUND;
      A_ROUND: state_d = A_DONE;
      A_DONE:  state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    sbn    = opb_q[63] ^ sub_q;
    nan_a  = (opa_q[62:52] == ExpAllOnes) && (opa_q[51:0] != '0);
    nan_b  = (opb_q[62:52] == ExpAllOnes) && (opb_q[51:0] != '0);
    inf_a  = (opa_q[62:52] == ExpAllOnes) && (opa_q[51:0] == '0);
    inf_b  = (opb_q[62:52] == ExpAllOnes) && (opb_q[51:0] == '0);
    b_big  = opb_q[62:0] > opa_q[62:0];
    big    = b_big ? {sbn, opb_q[62:0]} : opa_q;
    sml    = b_big ? opa_q : {sbn, opb_q[62:0]};
    eb_raw = big[62:52];
    es_raw = sml[62:52];
    eb_adj = (eb_raw == '0) ? 11'd1 : eb_raw;
    es_adj = (es_raw == '0) ? 11'd1 : es_raw;
  end

  always_comb begin
    sm_mask  = ~({56{1'b1}} << d_q[5:0]);
    sm_shift = sm_q >> d_q[5:0];
    if (d_q >= 11'd56) begin
      sm_in = {55'd0, (sm_q != '0)};
    end else begin
      sm_in = sm_shift | {55'd0, ((sm_q & sm_mask) != '0)};
    end
  end

  always_comb begin
    lz = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (sum_q[i]) lz = 6'(55 - i);
    end
  end

  always_comb begin
    nrm_pre = nrm_q << sh_q;
    m53     = nrm_q[55:3];
    rnd_up  = nrm_q[2] & (nrm_q[1] | nrm_q[0] | m53[0]);
    m54     = {1'b0, m53} + {53'd0, rnd_up};
    if (m54[53]) begin
      mfin = m54[53:1];
      efin = e_q + 12'd1;
    end else begin
      mfin = m54[52:0];
      efin = e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          opa_q <= req_i.a;
          opb_q <= req_i.b;
          sub_q <= req_i.sub;
        end
      end
      A_PREP: begin
        if (nan_a) begin
          res_q <= opa_q | QuietBit;
        end else if (nan_b) begin
          res_q <= opb_q | QuietBit;
        end else if (inf_a && inf_b && (opa_q[63] != sbn)) begin
          res_q <= DefaultNan;
        end else if (inf_a) begin
          res_q <= opa_q;
        end else if (inf_b) begin
          res_q <= {sbn, opb_q[62:0]};
        end
        sign_q   <= big[63];
        zsign_q  <= opa_q[63] & sbn;
        effsub_q <= opa_q[63] ^ sbn;
        e_q      <= {1'b0, eb_adj};
        d_q      <= eb_adj - es_adj;
        bm_q     <= {(eb_raw != '0), big[51:0], 3'b000};
        sm_q     <= {(es_raw != '0), sml[51:0], 3'b000};
      end
      A_ALIGN: sm_q <= sm_in;
      A_ADD: begin
        if (effsub_q) sum_q <= {1'b0, bm_q} - {1'b0, sm_q};
        else sum_q <= {1'b0, bm_q} + {1'b0, sm_q};
      end
      A_LZC: begin
        if (sum_q == '0) begin
          res_q <= {zsign_q, 63'd0};
        end else if (sum_q[56]) begin
          nrm_q <= {sum_q[56:2], sum_q[1] | sum_q[0]};
          e_q   <= e_q + 12'd1;
          sh_q  <= '0;
        end else begin
          nrm_q <= sum_q[55:0];
          sh_q  <= ({6'd0, lz} < (e_q - 12'd1)) ? lz : 6'(e_q - 12'd1);
        end
      end
      A_NORM: begin
        nrm_q <= nrm_pre;
        e_q   <= e_q - {6'd0, sh_q};
      end
      A_ROUND: begin
        if (efin >= 12'd2047) begin
          res_q <= {sign_q, ExpAllOnes, 52'd0};
        end else begin
          res_q <= {sign_q, (mfin[52] ? efin[10:0] : 11'd0), mfin[51:0]};
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done = (state_q == A_DONE);
  assign rsp_o.res  = res_q;

endmodule

// File: sv/exact_float_running_sum_top.sv
// Top level of the exact floating-point running sum with its term sequencer.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | value_bits_i, start_req_i, last_i
//  out     | output    | out_valid_o/out_stall_i | sum_bits_o, is_last_o, overflow_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (emit_mode)
//
// For n stored terms an item runs n Two-Sum steps; each reads its term from the store and makes
// six passes through the one shared double adder. If a result is emitted, a summing pass then
// adds the stored terms in turn. A term overflow adds a pass folding the value into the top
// stored term. The input is stalled for the whole of an item; a new transfer is taken once the
// result is in the output register, or once the terms are stored if none is emitted. Reset
// clears the term count, the overflow flag and the emit mode; the term store needs no clearing.
module exact_float_running_sum_top
  import efrs_pkg::*;
#(
  parameter int unsigned MaxTerms = DefMaxTerms
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  input  logic        start_req_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] sum_bits_o,
  output logic        is_last_o,
  output logic        overflow_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxTerms);
  localparam int unsigned CW = $clog2(MaxTerms + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxTerms);
  localparam logic [AW-1:0] TopAddr = AW'(MaxTerms - 1);

  seq_state_e state_q, state_d;

  logic [CW-1:0] cnt_q, rd_q, wr_q;
  logic [2:0]    op_q;
  logic          ovf_q, mode_q, last_q;
  logic [63:0]   a_q, b_q, x_q, bv_q, av_q, br_q, ar_q, t_q;
  logic          out_valid_q, out_last_q, out_ovf_q;
  logic [63:0]   out_sum_q;

  add_req_t      add_req;
  add_rsp_t      add_rsp;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;
  logic          in_fire, emit, y_nz, out_free;
  logic [CW-1:0] rd_inc, cnt_start;

  efrs_ram #(.Width(64), .Depth(MaxTerms)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  efrs_fpadd u_add (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (add_req),
    .rsp_o  (add_rsp)
  );

  assign in_fire   = in_valid_i && (state_q == S_IDLE);
  assign emit      = !(mode_q && !last_q);
  assign y_nz      = add_rsp.res[62:0] != '0;
  assign rd_inc    = rd_q + CW'(1);
  assign cnt_start = start_req_i ? '0 : cnt_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = (cnt_start == '0) ? S_FIN : S_TERM_RD;
      end
      S_TERM_RD:   state_d = S_TERM_WAIT;
      S_TERM_WAIT: state_d = S_TS_GO;
      S_TS_GO:     state_d = S_TS_BUSY;
      S_TS_BUSY: begin
        if (add_rsp.done) begin
          if (op_q != OP_Y) state_d = S_TS_GO;
          else if (rd_inc == cnt_q) state_d = S_FIN;
          else state_d = S_TERM_RD;
        end
      end
      S_FIN: begin
        if (wr_q == MaxCnt) state_d = S_TOP_RD;
        else state_d = emit ? S_SUM_RD : S_IDLE;
      end
      S_TOP_RD:   state_d = S_TOP_WAIT;
      S_TOP_WAIT: state_d = S_TOP_GO;
      S_TOP_GO:   state_d = S_TOP_BUSY;
      S_TOP_BUSY: begin
        if (add_rsp.done) state_d = emit ? S_SUM_RD : S_IDLE;
      end
      S_SUM_RD:   state_d = S_SUM_WAIT;
      S_SUM_WAIT: state_d = S_SUM_GO;
      S_SUM_GO:   state_d = S_SUM_BUSY;
      S_SUM_BUSY: begin
        if (add_rsp.done) state_d = (rd_inc == cnt_q) ? S_EMIT : S_SUM_RD;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    add_req   = '0;
    ram_we    = 1'b0;
    ram_waddr = wr_q[AW-1:0];
    ram_wdata = add_rsp.res;
    ram_raddr = rd_q[AW-1:0];
    case (state_q)
      S_TS_GO: begin
        add_req.start = 1'b1;
        case (op_q)
          OP_X:    begin add_req.a = a_q;  add_req.b = b_q;  end
          OP_BV:   begin add_req.a = x_q;  add_req.b = a_q;  add_req.sub = 1'b1; end
          OP_AV:   begin add_req.a = x_q;  add_req.b = bv_q; add_req.sub = 1'b1; end
          OP_BR:   begin add_req.a = b_q;  add_req.b = bv_q; add_req.sub = 1'b1; end
          OP_AR:   begin add_req.a = a_q;  add_req.b = av_q; add_req.sub = 1'b1; end
          OP_Y:    begin add_req.a = ar_q; add_req.b = br_q; end
          default: ;
        endcase
      end
      S_TS_BUSY: ram_we = add_rsp.done && (op_q == OP_Y) && y_nz;
      S_FIN: begin
        ram_we    = wr_q != MaxCnt;
        ram_wdata = a_q;
      end
      S_TOP_RD: ram_raddr = TopAddr;
      S_TOP_GO: begin
        add_req.start = 1'b1;
        add_req.a     = b_q;
        add_req.b     = a_q;
      end
      S_TOP_BUSY: begin
        ram_we    = add_rsp.done;
        ram_waddr = TopAddr;
      end
      S_SUM_GO: begin
        add_req.start = 1'b1;
        add_req.a     = t_q;
        add_req.b     = b_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      op_q        <= OP_X;
      ovf_q       <= 1'b0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cnt_q <= cnt_start;
            rd_q  <= '0;
            wr_q  <= '0;
            op_q  <= OP_X;
            if (start_req_i) ovf_q <= 1'b0;
          end
        end
        S_TS_BUSY: begin
          if (add_rsp.done) begin
            if (op_q != OP_Y) begin
              op_q <= op_q + 3'd1;
            end else begin
              op_q <= OP_X;
              rd_q <= rd_inc;
              if (y_nz) wr_q <= wr_q + CW'(1);
            end
          end
        end
        S_FIN: begin
          if (wr_q != MaxCnt) cnt_q <= wr_q + CW'(1);
          rd_q <= '0;
        end
        S_TOP_BUSY: begin
          if (add_rsp.done) begin
            cnt_q <= MaxCnt;
            ovf_q <= 1'b1;
            rd_q  <= '0;
          end
        end
        S_SUM_BUSY: begin
          if (add_rsp.done) rd_q <= rd_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          a_q    <= value_bits_i;
          last_q <= last_i;
        end
      end
      S_TERM_WAIT, S_TOP_WAIT, S_SUM_WAIT: b_q <= ram_rdata;
      S_TS_BUSY: begin
        if (add_rsp.done) begin
          case (op_q)
            OP_X:    x_q  <= add_rsp.res;
            OP_BV:   bv_q <= add_rsp.res;
            OP_AV:   av_q <= add_rsp.res;
            OP_BR:   br_q <= add_rsp.res;
            OP_AR:   ar_q <= add_rsp.res;
            OP_Y:    a_q  <= x_q;
            default: ;
          endcase
        end
      end
      S_FIN:      t_q <= '0;
      S_TOP_BUSY: t_q <= '0;
      S_SUM_BUSY: begin
        if (add_rsp.done) t_q <= add_rsp.res;
      end
      S_EMIT: begin
        if (out_free) begin
          out_sum_q  <= t_q;
          out_last_q <= last_q;
          out_ovf_q  <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign sum_bits_o  = out_sum_q;
  assign is_last_o   = out_last_q;
  assign overflow_o  = out_ovf_q;

  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TS_BUSY) |-> (wr_q <= rd_q))
    else $error("Write index has overtaken read index.");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_rsp.done |-> (state_q == S_TS_BUSY || state_q == S_TOP_BUSY ||
                      state_q == S_SUM_BUSY))
    else $error("Adder finished outside a waiting state.");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q <= MaxCnt))
    else $error("Term count exceeds the store depth.");

endmodule

// File: tb/sv/testbench.sv
// Testbench for the exact floating-point running sum, with directed, pressure and random tests.
module testbench;
  import efrs_pkg::*;

  localparam int unsigned Terms = DefMaxTerms;
  localparam int unsigned DrainCycles = 4000;

  typedef struct {
    logic [63:0] sum_bits;
    logic        is_last;
    logic        overflow;
  } sum_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] value_bits_i = '0;
  logic        start_req_i = 1'b0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] sum_bits_o;
  logic        is_last_o;
  logic        overflow_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  exact_float_running_sum_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_bits_i(value_bits_i),
    .start_req_i (start_req_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_bits_o  (sum_bits_o),
    .is_last_o   (is_last_o),
    .overflow_o  (overflow_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  real         exp_terms[Terms];
  int unsigned exp_count = 0;
  bit          exp_ovf = 1'b0;
  bit          total_mode = 1'b0;
  sum_result_t expected_sums[$];
  int unsigned mismatches = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned stall_left = 0;
  logic [63:0] prev_value = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Adds one value to the expansion by a Two-Sum chain and queues the sum it reports.
  function automatic void predict_sum(logic [63:0] vb, logic st, logic lst);
    real a, b, x, bv, av, y, t;
    int unsigned wr;
    sum_result_t r;
    wr = 0;
    if (st) begin
      exp_count = 0;
      exp_ovf = 1'b0;
    end
    a = $bitstoreal(vb);
    for (int unsigned rd = 0; rd < exp_count; rd++) begin
      b = exp_terms[rd];
      x = a + b;
      bv = x - a;
      av = x - bv;
      y = (a - av) + (b - bv);
      if (y != 0.0) begin
        exp_terms[wr] = y;
        wr++;
      end
      a = x;
    end
    if (wr < Terms) begin
      exp_terms[wr] = a;
      exp_count = wr + 1;
    end else begin
      exp_terms[Terms-1] = exp_terms[Terms-1] + a;
      exp_count = Terms;
      exp_ovf = 1'b1;
    end
    if (total_mode && !lst) return;
    t = 0.0;
    for (int unsigned i = 0; i < exp_count; i++) t = t + exp_terms[i];
    r.sum_bits = $realtobits(t);
    r.is_last = lst;
    r.overflow = exp_ovf;
    expected_sums.push_back(r);
  endfunction

  task automatic send_value(logic [63:0] vb, logic st, logic lst);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_bits_i <= vb;
    start_req_i <= st;
    last_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    predict_sum(vb, st, lst);
    prev_value = vb;
  endtask

  task automatic end_sending();
    in_valid_i <= 1'b0;
    wait (expected_sums.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    end_sending();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    total_mode = m;
  endtask

  function automatic logic [63:0] rand_double(bit wide);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = {~prev_value[63], prev_value[62:0]};
      1: v = $realtobits(real'(int'($urandom_range(0, 2000)) - 1000));
      default: if (!wide) v[62:52] = 11'(1023 + $urandom_range(0, 120) - 60);
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    sum_result_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: sum %h", sum_bits_o);
      end else begin
        e = expected_sums.pop_front();
        if (sum_bits_o !== e.sum_bits || is_last_o !== e.is_last
            || overflow_o !== e.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected sum %h last %b ovf %b, got sum %h last %b ovf %b",
                     e.sum_bits, e.is_last, e.overflow, sum_bits_o, is_last_o, overflow_o);
        end
      end
    end
  end

  task automatic test_special_values();
    logic [63:0] specials[$];
    specials = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001,
                 64'h000F_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
                 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
                 64'h3FF0_0000_0000_0000, 64'h3CA0_0000_0000_0000,
                 64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                 64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
                 64'hFFFF_FFFF_FFFF_FFFF};
    // Items before any start add to the empty expansion; later starts clear infinities.
    for (int i = 0; i < 11; i++) send_value(specials[i], 1'b0, i == 10);
    send_value(specials[11], 1'b1, 1'b0);
    send_value(specials[12], 1'b0, 1'b1);
    for (int i = 13; i < specials.size(); i++) send_value(specials[i], 1'b1, 1'b1);
  endtask

  task automatic test_total_mode();
    write_mode(1'b1);
    for (int s = 0; s < 6; s++) begin
      for (int i = 0; i < 4; i++) send_value(rand_double(0), i == 0, i == 3);
    end
    write_mode(1'b0);
  endtask

  task automatic test_back_pressure();
    hold_cycles = 3000;
    for (int i = 0; i < 8; i++) send_value(rand_double(0), i == 0, i == 7);
    in_valid_i <= 1'b0;
    wait (expected_sums.size() == 0);
    for (int i = 0; i < 4; i++) send_value(rand_double(0), i == 0, i == 3);
  endtask

  task automatic test_deep_expansion();
    for (int s = 0; s < 2; s++) begin
      if (s == 1) write_mode(1'b1);
      for (int i = 0; i < 70; i++) send_value(rand_double(1), i == 0, i == 69);
    end
    write_mode(1'b0);
  endtask

  task automatic test_random_sequences();
    int len;
    bit wide;
    for (int n = 0; n < 900;) begin
      if (n >= 450 && n < 460) write_mode(1'b1);
      if (n >= 750) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      len = $urandom_range(1, 8);
      wide = $urandom_range(0, 4) == 0;
      for (int i = 0; i < len; i++) begin
        send_value(rand_double(wide), (i == 0) ^ ($urandom_range(0, 15) == 0),
                   (i == len - 1) ^ ($urandom_range(0, 15) == 0));
        n++;
      end
      if (n >= 450 && n < 460) n = 460;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_total_mode();
    test_back_pressure();
    test_deep_expansion();
    test_random_sequences();
    end_sending();
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/efrs_pkg.sv
sv/efrs_ram.sv
sv/efrs_fpadd.sv
sv/exact_float_running_sum_top.sv
tb/sv/testbench.sv
